@@ hdl/bdlp_pkg.sv @@
// Package with widths, bit positions and codes of the button debounce block.
`timescale 1ns / 1ps
package bdlp_pkg;

  localparam int unsigned BtnW      = 8;
  localparam int unsigned ClickW    = 5;
  localparam int unsigned TickW     = 32;
  localparam int unsigned EventW    = 10;
  localparam int unsigned CountW    = 4;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  // Bit positions in the raw and debounced button word.
  localparam int unsigned BtnZero  = 0;
  localparam int unsigned BtnMenu  = 1;
  localparam int unsigned BtnF1    = 2;
  localparam int unsigned BtnF2    = 3;
  localparam int unsigned BtnF3    = 4;
  localparam int unsigned BtnF4    = 5;
  localparam int unsigned BtnStart = 6;
  localparam int unsigned BtnEnc   = 7;

  // Buttons whose presses are reported only through the click flags.
  localparam logic [BtnW-1:0] ClickOwned = 8'h5E;
  // Buttons whose press raises a key click.
  localparam logic [BtnW-1:0] BeepOnPress = 8'h7B;

  // Bit positions in the event mask.
  localparam int unsigned EvZero     = 0;
  localparam int unsigned EvMenu     = 1;
  localparam int unsigned EvF2       = 2;
  localparam int unsigned EvF3       = 3;
  localparam int unsigned EvF4       = 4;
  localparam int unsigned EvStart    = 5;
  localparam int unsigned EvF1Short  = 6;
  localparam int unsigned EvEncShort = 7;
  localparam int unsigned EvF1Long   = 8;
  localparam int unsigned EvEncLong  = 9;

  // Register reset values.
  localparam logic [CountW-1:0] StablePollCountRst = 4'd5;
  localparam logic [HoldW-1:0]  LongPressMsRst     = 16'd500;
  localparam logic              KeySoundEnableRst  = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_LEAVE   = 2'd1,
    ACT_RETURN  = 2'd2,
    ACT_CONFIRM = 2'd3
  } menu_action_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_STABLE_POLL_COUNT = 2'd0,
    CFG_LONG_PRESS_MS     = 2'd1,
    CFG_KEY_SOUND_ENABLE  = 2'd2
  } cfg_reg_e;

endpackage

@@ hdl/bdlp_if.sv @@
// Handshake interfaces for the poll input, result output and register write channels.
`timescale 1ns / 1ps
interface bdlp_in_if import bdlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BtnW-1:0]   raw_buttons;
  logic [ClickW-1:0] click_flags;
  logic [TickW-1:0]  tick_ms;
  logic              in_menu;

  modport source (output valid, output raw_buttons, output click_flags,
                  output tick_ms, output in_menu, input ready);
  modport sink   (input valid, input raw_buttons, input click_flags,
                  input tick_ms, input in_menu, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EventW-1:0] event_mask;
  logic [1:0]        menu_action;
  logic              beep;
  logic [BtnW-1:0]   stable_buttons;

  modport source (output valid, output event_mask, output menu_action,
                  output beep, output stable_buttons, input ready);
  modport sink   (input valid, input event_mask, input menu_action,
                  input beep, input stable_buttons, output ready);
endinterface

interface bdlp_cfg_if import bdlp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/button_debounce_long_press_unit.sv @@
// Button debounce with click-flag presses and long-press detection, top level.
`timescale 1ns / 1ps
// Usage overview.
// Each item on in_i is one poll: eight raw button levels, five interrupt click
// flags, a wrapping millisecond timestamp and the menu-open flag. For every
// poll exactly one item leaves on out_o with the event mask, the menu action,
// the beep request and the debounced button word after that poll.
// The poll is first captured in an input register. The debounce, edge and hold
// logic then works on it against the stored state and the result is written to
// the output register, from which it is offered on out_o. Throughput is one item
// per cycle while out_o does not stall. The input register advances whenever the
// output register is empty or is being taken in the same cycle, so the output
// register parts the two sides and a stall only backs up once both hold an item.
// While out_o is stalled the offered result holds; in_i.ready drops only when
// the input register is full behind a stalled output.
// Registers are written on cfg_i, which is always ready; writes are expected
// only while the block is idle, and an index beyond the register list is ignored.
// Reset (rst_ni low, asynchronous) empties both registers, clears all debounce
// and hold state and restores the register defaults.
module button_debounce_long_press_unit import bdlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdlp_in_if.sink   in_i,
  bdlp_out_if.source out_o,
  bdlp_cfg_if.sink  cfg_i
);

  // Configuration registers.
  logic [CountW-1:0] stable_poll_count_q;
  logic [HoldW-1:0]  long_press_ms_q;
  logic              key_sound_enable_q;

  // Input register.
  logic              s1_valid_q;
  logic [BtnW-1:0]   s1_raw_q;
  logic [ClickW-1:0] s1_clicks_q;
  logic [TickW-1:0]  s1_now_q;
  logic              s1_menu_q;

  // Debounce and hold state.
  logic [BtnW-1:0]   last_sample_q, last_sample_d;
  logic [CountW-1:0] stable_counter_q, stable_counter_d;
  logic [BtnW-1:0]   debounced_q, debounced_d;
  logic [BtnW-1:0]   previous_q;
  logic [TickW-1:0]  f1_start_q, f1_start_d;
  logic              f1_track_q, f1_track_d;
  logic              f1_done_q, f1_done_d;
  logic [TickW-1:0]  enc_start_q, enc_start_d;
  logic              enc_track_q, enc_track_d;
  logic              enc_done_q, enc_done_d;

  // Output register.
  logic              out_valid_q;
  logic [EventW-1:0] event_q, event_d;
  menu_action_e      action_q, action_d;
  logic              beep_q, beep_d;
  logic [BtnW-1:0]   stable_q;

  logic              advance;
  logic [BtnW-1:0]   pressed;
  logic [BtnW-1:0]   released;
  logic [TickW-1:0]  f1_elapsed;
  logic [TickW-1:0]  enc_elapsed;
  logic              f1_fire;
  logic              enc_fire;
  logic              beep_raw;

  // The poll in the input register moves on when the output register can take it.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_poll_count_q <= StablePollCountRst;
      long_press_ms_q     <= LongPressMsRst;
      key_sound_enable_q  <= KeySoundEnableRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_STABLE_POLL_COUNT: stable_poll_count_q <= cfg_i.data[CountW-1:0];
        CFG_LONG_PRESS_MS:     long_press_ms_q     <= cfg_i.data[HoldW-1:0];
        CFG_KEY_SOUND_ENABLE:  key_sound_enable_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_raw_q    <= in_i.raw_buttons;
      s1_clicks_q <= in_i.click_flags;
      s1_now_q    <= in_i.tick_ms;
      s1_menu_q   <= in_i.in_menu;
    end
  end

  // Debounce: the raw word must repeat until the counter reaches the set count.
  always_comb begin
    last_sample_d = s1_raw_q;
    if (s1_raw_q != last_sample_q) begin
      stable_counter_d = '0;
    end else if (stable_counter_q < stable_poll_count_q) begin
      stable_counter_d = stable_counter_q + 1'b1;
    end else begin
      stable_counter_d = stable_counter_q;
    end
    debounced_d = (stable_counter_d >= stable_poll_count_q) ? s1_raw_q : debounced_q;
  end

  // Edges of the debounced word; interrupt-owned presses come from the clicks.
  always_comb begin
    pressed  = debounced_d & ~previous_q & ~ClickOwned;
    released = previous_q & ~debounced_d;
    pressed[BtnMenu]  = pressed[BtnMenu]  | s1_clicks_q[0];
    pressed[BtnF1]    = pressed[BtnF1]    | s1_clicks_q[1];
    pressed[BtnF2]    = pressed[BtnF2]    | s1_clicks_q[2];
    pressed[BtnF3]    = pressed[BtnF3]    | s1_clicks_q[3];
    pressed[BtnStart] = pressed[BtnStart] | s1_clicks_q[4];
  end

  // Hold tracking for f1 and the encoder, judged from the raw level. A press
  // restarts the hold time, so the elapsed time is taken from the new start.
  always_comb begin
    f1_start_d = pressed[BtnF1] ? s1_now_q : f1_start_q;
    f1_track_d = (pressed[BtnF1] || f1_track_q) && s1_raw_q[BtnF1];
    f1_done_d  = f1_done_q && !pressed[BtnF1];
    f1_elapsed = s1_now_q - f1_start_d;
    f1_fire    = s1_raw_q[BtnF1] && f1_track_d && !f1_done_d &&
                 (f1_elapsed >= {{(TickW-HoldW){1'b0}}, long_press_ms_q});
    if (f1_fire) begin
      f1_done_d = 1'b1;
    end
    if (released[BtnF1]) begin
      f1_track_d = 1'b0;
    end

    enc_start_d = pressed[BtnEnc] ? s1_now_q : enc_start_q;
    enc_track_d = (pressed[BtnEnc] || enc_track_q) && s1_raw_q[BtnEnc];
    enc_done_d  = enc_done_q && !pressed[BtnEnc];
    enc_elapsed = s1_now_q - enc_start_d;
    enc_fire    = s1_raw_q[BtnEnc] && enc_track_d && !enc_done_d &&
                  (enc_elapsed >= {{(TickW-HoldW){1'b0}}, long_press_ms_q});
    if (enc_fire) begin
      enc_done_d = 1'b1;
    end
    if (released[BtnEnc]) begin
      enc_track_d = 1'b0;
    end
  end

  // Result: long events always, button events only with the menu closed,
  // and at most one menu action per poll with the menu open.
  always_comb begin
    event_d = '0;
    event_d[EvF1Long]  = f1_fire;
    event_d[EvEncLong] = enc_fire;
    action_d = ACT_NONE;
    beep_raw = f1_fire || enc_fire || ((pressed & BeepOnPress) != '0);
    if (s1_menu_q) begin
      if (pressed[BtnMenu]) begin
        action_d = ACT_LEAVE;
      end else if (pressed[BtnF1]) begin
        if (!f1_done_d) begin
          action_d = ACT_RETURN;
        end
      end else if (released[BtnEnc] && !enc_done_d) begin
        beep_raw = 1'b1;
        action_d = ACT_CONFIRM;
      end
    end else begin
      event_d[EvZero]  = pressed[BtnZero];
      event_d[EvMenu]  = pressed[BtnMenu];
      event_d[EvF2]    = pressed[BtnF2];
      event_d[EvF3]    = pressed[BtnF3];
      event_d[EvF4]    = pressed[BtnF4];
      event_d[EvStart] = pressed[BtnStart];
      if (released[BtnF1] && !f1_done_d) begin
        beep_raw = 1'b1;
        event_d[EvF1Short] = 1'b1;
      end
      if (released[BtnEnc] && !enc_done_d) begin
        beep_raw = 1'b1;
        event_d[EvEncShort] = 1'b1;
      end
    end
    beep_d = beep_raw && key_sound_enable_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sample_q    <= '0;
      stable_counter_q <= '0;
      debounced_q      <= '0;
      previous_q       <= '0;
      f1_start_q       <= '0;
      f1_track_q       <= 1'b0;
      f1_done_q        <= 1'b0;
      enc_start_q      <= '0;
      enc_track_q      <= 1'b0;
      enc_done_q       <= 1'b0;
    end else if (advance) begin
      last_sample_q    <= last_sample_d;
      stable_counter_q <= stable_counter_d;
      debounced_q      <= debounced_d;
      previous_q       <= debounced_d;
      f1_start_q       <= f1_start_d;
      f1_track_q       <= f1_track_d;
      f1_done_q        <= f1_done_d;
      enc_start_q      <= enc_start_d;
      enc_track_q      <= enc_track_d;
      enc_done_q       <= enc_done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q  <= event_d;
      action_q <= action_d;
      beep_q   <= beep_d;
      stable_q <= debounced_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.event_mask     = event_q;
  assign out_o.menu_action    = action_q;
  assign out_o.beep           = beep_q;
  assign out_o.stable_buttons = stable_q;

endmodule

@@ hdl/bdlp_checker.sv @@
// Port-level checker for the button debounce block and its bind statement.
`timescale 1ns / 1ps
module bdlp_checker import bdlp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [EventW-1:0] event_mask_i,
  input logic [1:0]        menu_action_i,
  input logic              beep_i,
  input logic [BtnW-1:0]   stable_buttons_i
);

  // A stalled result item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(event_mask_i) && $stable(menu_action_i) && $stable(beep_i) &&
      $stable(stable_buttons_i))
    else $error("result item changed while stalled");

  // Input backs up only behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without an output stall");

  // Button events and a menu action never come in the same item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_mask_i[EvStart:EvZero] != '0 ||
                    event_mask_i[EvEncShort:EvF1Short] != '0) |->
      menu_action_i == ACT_NONE)
    else $error("button events together with a menu action");

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .event_mask_i     (out_o.event_mask),
  .menu_action_i    (out_o.menu_action),
  .beep_i           (out_o.beep),
  .stable_buttons_i (out_o.stable_buttons)
);

@@ sim/tb.sv @@
// Self-checking testbench for the button debounce and long-press unit.
`timescale 1ns / 1ps
module tb;
  import bdlp_pkg::*;

  // Register index with no register behind it; writes to it must be dropped.
  localparam logic [CfgIndexW-1:0] CfgSpare = 2'd3;
  localparam int unsigned MaxWait     = 17;
  localparam int unsigned SettleDelay = 4;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted  = 100;

  // One poll as it travels on the input channel.
  typedef struct packed {
    logic [BtnW-1:0]   raw;
    logic [ClickW-1:0] clicks;
    logic [TickW-1:0]  tick;
    logic              menu;
  } poll_t;

  // What the unit must report for one poll.
  typedef struct packed {
    logic [EventW-1:0] ev_mask;
    menu_action_e      action;
    logic              beep;
    logic [BtnW-1:0]   stable;
  } outcome_t;

  // Long-press tracker of one button; fired is set on the poll the long press triggers.
  typedef struct packed {
    logic [TickW-1:0] since;
    logic             tracking;
    logic             done;
    logic             fired;
  } hold_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bdlp_in_if  in_if ();
  bdlp_out_if out_if ();
  bdlp_cfg_if cfg_if ();

  button_debounce_long_press_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Our own copy of the three registers, updated when a write is accepted.
  logic [CountW-1:0] cfg_stable;
  logic [HoldW-1:0]  cfg_hold_ms;
  logic              cfg_sound;

  // Mirror of the debounce and hold state inside the unit.
  logic [BtnW-1:0]   db_last;
  logic [CountW-1:0] db_count;
  logic [BtnW-1:0]   db_word;
  logic [BtnW-1:0]   db_prev;
  hold_t             f1_hold;
  hold_t             enc_hold;

  // Polls waiting to be offered, and outcomes waiting for their result item.
  poll_t       poll_q[$];
  outcome_t    due_results[$];
  poll_t       cur_poll;
  outcome_t    want_now;
  int unsigned polls_queued = 0;
  int unsigned polls_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;

  // Traffic shaping. The idle enables are switched per phase so that some
  // stretches run back to back and others are full of gaps and stalls.
  bit          run_en      = 1'b0;
  bit          in_idle_en  = 1'b0;
  bit          out_idle_en = 1'b0;
  int unsigned in_wait     = 0;
  int unsigned out_wait    = 0;
  int unsigned out_draw;

  // Stimulus bookkeeping: the running millisecond clock and the word that the
  // current press sequence is holding.
  logic [TickW-1:0] now_ms;
  logic [BtnW-1:0]  held_word;

  // Cycles a side sits out after an item. Mostly short, now and then up to
  // MaxWait, so gaps land on every stage of the two-register pipeline.
  function automatic int unsigned draw_wait(bit enable);
    if (!enable) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, MaxWait);
    return $urandom_range(0, 2);
  endfunction

  // One step of a long-press tracker. The hold time is the modular 32-bit
  // difference, so a timestamp that wraps through zero still counts up.
  function automatic hold_t hold_advance(hold_t h, logic pressed, logic held,
                                         logic [TickW-1:0] now);
    logic [TickW-1:0] held_for;
    h.fired = 1'b0;
    if (pressed) begin
      h.since    = now;
      h.tracking = 1'b1;
      h.done     = 1'b0;
    end
    if (!held) h.tracking = 1'b0;
    held_for = now - h.since;
    if (held && h.tracking && !h.done && held_for >= TickW'(cfg_hold_ms)) begin
      h.done  = 1'b1;
      h.fired = 1'b1;
    end
    return h;
  endfunction

  // Advances the mirrored state by one poll and returns what the unit must say.
  function automatic outcome_t predict_poll(poll_t p);
    outcome_t   o;
    logic [BtnW-1:0] rise;
    logic [BtnW-1:0] fall;
    logic       chirp;
    o     = '0;
    chirp = 1'b0;

    // The whole word has to repeat before it is taken. With a stable count of
    // zero the comparison always passes and the raw word goes straight through.
    if (p.raw != db_last) begin
      db_last  = p.raw;
      db_count = '0;
    end else if (db_count < cfg_stable) begin
      db_count = db_count + 1'b1;
    end
    if (db_count >= cfg_stable) db_word = p.raw;

    // Presses of click-owned buttons come only from the interrupt flags.
    rise    = db_word & ~db_prev & ~ClickOwned;
    fall    = db_prev & ~db_word;
    db_prev = db_word;
    if (p.clicks[0]) rise[BtnMenu]  = 1'b1;
    if (p.clicks[1]) rise[BtnF1]    = 1'b1;
    if (p.clicks[2]) rise[BtnF2]    = 1'b1;
    if (p.clicks[3]) rise[BtnF3]    = 1'b1;
    if (p.clicks[4]) rise[BtnStart] = 1'b1;

    // Long presses follow the raw level, not the debounced word.
    f1_hold = hold_advance(f1_hold, rise[BtnF1], p.raw[BtnF1], p.tick);
    if (f1_hold.fired) begin
      o.ev_mask[EvF1Long] = 1'b1;
      chirp = 1'b1;
    end
    if (fall[BtnF1]) f1_hold.tracking = 1'b0;
    enc_hold = hold_advance(enc_hold, rise[BtnEnc], p.raw[BtnEnc], p.tick);
    if (enc_hold.fired) begin
      o.ev_mask[EvEncLong] = 1'b1;
      chirp = 1'b1;
    end
    if (fall[BtnEnc]) enc_hold.tracking = 1'b0;

    if (|(rise & BeepOnPress)) chirp = 1'b1;

    o.action = ACT_NONE;
    if (p.menu) begin
      // With the menu open only one action is taken, in priority order.
      if (rise[BtnMenu]) begin
        o.action = ACT_LEAVE;
      end else if (rise[BtnF1]) begin
        if (!f1_hold.done) o.action = ACT_RETURN;
      end else if (fall[BtnEnc] && !enc_hold.done) begin
        chirp    = 1'b1;
        o.action = ACT_CONFIRM;
      end
    end else begin
      o.ev_mask[EvZero]  = rise[BtnZero];
      o.ev_mask[EvMenu]  = rise[BtnMenu];
      o.ev_mask[EvF2]    = rise[BtnF2];
      o.ev_mask[EvF3]    = rise[BtnF3];
      o.ev_mask[EvF4]    = rise[BtnF4];
      o.ev_mask[EvStart] = rise[BtnStart];
      // A release counts as a short press only if no long press fired.
      if (fall[BtnF1] && !f1_hold.done) begin
        chirp = 1'b1;
        o.ev_mask[EvF1Short] = 1'b1;
      end
      if (fall[BtnEnc] && !enc_hold.done) begin
        chirp = 1'b1;
        o.ev_mask[EvEncShort] = 1'b1;
      end
    end

    o.beep   = chirp & cfg_sound;
    o.stable = db_word;
    return o;
  endfunction

  task automatic report(string msg);
    if (errors < MaxPrinted) $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic queue_poll(logic [BtnW-1:0] raw, logic [ClickW-1:0] clicks,
                            logic [TickW-1:0] tick, logic menu);
    poll_t p;
    p.raw    = raw;
    p.clicks = clicks;
    p.tick   = tick;
    p.menu   = menu;
    poll_q.push_back(p);
    polls_queued++;
  endtask

  // Register write. The mirror follows only once the write item is accepted.
  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_STABLE_POLL_COUNT: cfg_stable  = val[CountW-1:0];
      CFG_LONG_PRESS_MS:     cfg_hold_ms = val[HoldW-1:0];
      CFG_KEY_SOUND_ENABLE:  cfg_sound   = val[0];
      default: ;
    endcase
  endtask

  // Writes all three registers. The unused data bits carry random junk that
  // the unit has to drop; optionally the spare index is hit as well.
  task automatic apply_setting(logic [CountW-1:0] stable, logic [HoldW-1:0] hold_ms,
                               logic sound, bit with_spare);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'($urandom);
    d[CountW-1:0] = stable;
    write_reg(CFG_STABLE_POLL_COUNT, d);
    write_reg(CFG_LONG_PRESS_MS, CfgDataW'(hold_ms));
    d = CfgDataW'($urandom);
    d[0] = sound;
    write_reg(CFG_KEY_SOUND_ENABLE, d);
    if (with_spare) write_reg(CfgSpare, CfgDataW'($urandom));
  endtask

  // Every poll yields one result item, so once nothing is owed the unit is
  // idle; the short pause covers the two pipeline registers.
  task automatic wait_idle();
    while (polls_taken != polls_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  // Random polls. Most of them form press sequences: a new target word, mostly held
  // long enough to pass the debounce, sometimes with bounce at the start, the
  // click flags raised for owned buttons that go down, and the clock moving in
  // steps sized against the long-press time. The rest is pure noise.
  task automatic gen_random(int unsigned n_polls);
    int unsigned      made;
    int unsigned      len;
    int unsigned      k;
    int unsigned      mode;
    int unsigned      bounce;
    int unsigned      step_kind;
    int unsigned      stab;
    int unsigned      hold;
    logic [BtnW-1:0]  target;
    logic [BtnW-1:0]  rise;
    logic [BtnW-1:0]  raw;
    logic [ClickW-1:0] flags;
    logic [TickW-1:0] step;
    logic             menu;
    made = 0;
    stab = 32'(cfg_stable);
    hold = 32'(cfg_hold_ms);
    while (made < n_polls) begin
      if ($urandom_range(0, 9) < 7) begin
        mode   = $urandom_range(0, 7);
        target = held_word;
        if (mode < 4) begin
          target[$urandom_range(0, BtnW - 1)] ^= 1'b1;
        end else if (mode < 6) begin
          target = BtnW'($urandom);
        end else if (mode == 6) begin
          target = '0;
        end else begin
          // Toggle the two buttons that have long-press detection.
          target[BtnF1]  = 1'($urandom_range(0, 1));
          target[BtnEnc] = 1'($urandom_range(0, 1));
        end
        rise = target & ~held_word;
        menu = ($urandom_range(0, 3) == 0);
        // Now and then the hold is too short to be accepted.
        if ($urandom_range(0, 6) == 0) len = $urandom_range(1, stab + 1);
        else len = stab + $urandom_range(1, 4);
        bounce    = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        step_kind = $urandom_range(0, 4);
        for (k = 0; k < len; k++) begin
          raw = target;
          if (k < bounce) raw[$urandom_range(0, BtnW - 1)] ^= 1'b1;
          flags = '0;
          if (k == 0) begin
            flags = {rise[BtnStart], rise[BtnF3], rise[BtnF2], rise[BtnF1], rise[BtnMenu]};
            if ($urandom_range(0, 9) == 0) flags ^= ClickW'($urandom);
          end else if ($urandom_range(0, 19) == 0) begin
            flags = ClickW'($urandom);
          end
          case (step_kind)
            0:       step = $urandom_range(0, 3);
            1:       step = $urandom_range(1, hold / 4 + 1);
            2:       step = $urandom_range(hold / 2, hold + 8);
            3:       step = $urandom;
            default: step = $urandom_range(0, 2 * hold + 2);
          endcase
          now_ms = now_ms + step;
          if ($urandom_range(0, 19) == 0) menu = ~menu;
          queue_poll(raw, flags, now_ms, menu);
        end
        made += len;
        held_word = target;
      end else begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          now_ms = now_ms + $urandom_range(0, 50);
          queue_poll(BtnW'($urandom), ClickW'($urandom), now_ms,
                     1'($urandom_range(0, 1)));
        end
        made += len;
      end
    end
  endtask

  // Input side. A poll is taken at an edge where valid and ready are both
  // high; the expected outcome is worked out right there, in order of
  // acceptance, against the mirrored state.
  always @(posedge clk_i) begin
    if (run_en) begin
      if (in_if.valid && in_if.ready) begin
        due_results.push_back(predict_poll(cur_poll));
        polls_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_wait != 0) begin
          in_wait     <= in_wait - 1;
          in_if.valid <= 1'b0;
        end else if (poll_q.size() != 0) begin
          cur_poll          = poll_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.raw_buttons <= cur_poll.raw;
          in_if.click_flags <= cur_poll.clicks;
          in_if.tick_ms     <= cur_poll.tick;
          in_if.in_menu     <= cur_poll.menu;
          in_wait           <= draw_wait(in_idle_en);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output side. Each result item is checked field by field against the
  // oldest outstanding outcome, and then ready is held low for a drawn stall.
  always @(posedge clk_i) begin
    if (run_en) begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected (events %h)",
                           results_seen, out_if.event_mask));
        end else begin
          want_now = due_results.pop_front();
          if (out_if.event_mask !== want_now.ev_mask)
            report($sformatf("result %0d: event_mask %h, expected %h",
                             results_seen, out_if.event_mask, want_now.ev_mask));
          if (out_if.menu_action !== want_now.action)
            report($sformatf("result %0d: menu_action %0d, expected %0d",
                             results_seen, out_if.menu_action, want_now.action));
          if (out_if.beep !== want_now.beep)
            report($sformatf("result %0d: beep %b, expected %b",
                             results_seen, out_if.beep, want_now.beep));
          if (out_if.stable_buttons !== want_now.stable)
            report($sformatf("result %0d: stable_buttons %h, expected %h",
                             results_seen, out_if.stable_buttons, want_now.stable));
        end
        results_seen++;
        out_draw      = draw_wait(out_idle_en);
        out_wait      <= out_draw;
        out_if.ready  <= (out_draw == 0);
      end else if (out_wait != 0) begin
        out_wait     <= out_wait - 1;
        out_if.ready <= (out_wait == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, a directed walk through the press and menu cases,
  // then random phases under several register settings.
  initial begin
    in_if.valid       = 1'b0;
    in_if.raw_buttons = '0;
    in_if.click_flags = '0;
    in_if.tick_ms     = '0;
    in_if.in_menu     = 1'b0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;

    cfg_stable  = StablePollCountRst;
    cfg_hold_ms = LongPressMsRst;
    cfg_sound   = KeySoundEnableRst;
    db_last     = '0;
    db_count    = '0;
    db_word     = '0;
    db_prev     = '0;
    f1_hold     = '0;
    enc_hold    = '0;
    now_ms      = '0;
    held_word   = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_en = 1'b1;

    // Directed part, at the reset register values. All buttons go down with
    // every click flag set just before the timestamp wraps; the F1 long press
    // fires across the wrap and the encoder one 500 ms after its debounced edge.
    queue_poll(8'h00, 5'h00, 32'h0000_0000, 1'b0);
    queue_poll(8'hFF, 5'h1F, 32'hFFFF_FE00, 1'b0);
    for (int k = 1; k <= 5; k++) queue_poll(8'hFF, 5'h00, 32'hFFFF_FE00 + 128 * k, 1'b0);
    queue_poll(8'hFF, 5'h00, 32'h0000_0274, 1'b0);
    // Release everything: both long presses are done, so no short events.
    for (int k = 0; k < 6; k++) queue_poll(8'h00, 5'h00, 32'h0000_0300 + k, 1'b0);
    // With the menu open: F1 click gives back, a short encoder press gives click.
    queue_poll(8'h84, 5'h02, 32'h0000_0400, 1'b1);
    for (int k = 1; k < 6; k++) queue_poll(8'h84, 5'h00, 32'h0000_0400 + k, 1'b1);
    for (int k = 0; k < 6; k++) queue_poll(8'h00, 5'h00, 32'h0000_0410 + k, 1'b1);
    // Menu press has priority over F1; all clicks with the menu closed.
    queue_poll(8'h00, 5'h01, 32'h0000_0500, 1'b1);
    queue_poll(8'h00, 5'h03, 32'h0000_0501, 1'b1);
    queue_poll(8'h00, 5'h1F, 32'h0000_0502, 1'b0);
    now_ms = 32'h0000_0600;
    wait_idle();

    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    gen_random(160);
    wait_idle();

    // Debounce count and hold time of one, key sound off, and a write to the spare index.
    apply_setting(4'd1, 16'd1, 1'b0, 1'b1);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    gen_random(180);
    wait_idle();

    apply_setting(4'd15, 16'hFFFF, 1'b1, 1'b0);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b0;
    gen_random(180);
    wait_idle();

    // Zero stable count passes the raw word through; zero hold time fires a
    // long press on the poll of the press itself.
    apply_setting(4'd0, 16'd0, 1'b1, 1'b0);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    gen_random(180);
    wait_idle();

    apply_setting(4'd3, 16'd40, 1'b1, 1'b1);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    gen_random(180);
    wait_idle();

    apply_setting(4'd7, 16'd1000, 1'b0, 1'b0);
    gen_random(180);
    wait_idle();

    apply_setting(CountW'($urandom_range(0, 15)), HoldW'($urandom_range(0, 3000)),
                  1'($urandom_range(0, 1)), 1'b1);
    in_idle_en  = 1'($urandom_range(0, 1));
    out_idle_en = 1'($urandom_range(0, 1));
    gen_random(180);
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run of this stimulus.
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bdlp_pkg.sv
hdl/bdlp_if.sv
hdl/button_debounce_long_press_unit.sv
hdl/bdlp_checker.sv
sim/tb.sv
